### src/mcl_pkg.sv
package mcl_pkg;

  localparam int TICK_W = 63;
  localparam int POS_W = 48;
  localparam int ACC_W = 52;
  localparam int RATE_W = 31;
  localparam int FAC_BITS = 20;
  localparam int CFG_AW = 4;

  localparam logic [31:0] TICK_FREQ_RST = 32'd1000000;
  localparam logic [RATE_W-1:0] ONE_Q16 = 31'd65536;
  localparam logic [31:0] RATE_EPS_LSB = 32'd65;
  localparam logic [40:0] ADV_SCALE = 41'd1000;
  localparam logic [63:0] DECAY_NUM = 64'd65536000;

  localparam logic [1:0] REG_TICK_FREQ = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_DRIFT = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_ANCHOR, S_PLAY, S_RATE, S_LAST, S_FINAL, S_DONE,
    P_START, P_ADV_MUL, P_ADV_DIV, P_OFF, P_DEC_MUL, P_DEC_DIV, P_FAC,
    P_FAC_MUL, P_MAG, P_SUM
  } state_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } mdu_op_t;

  typedef struct packed {
    logic start;
    mdu_op_t op;
  } mdu_req_t;

  typedef struct packed {
    logic [31:0] tick_freq;
    logic [31:0] offset_ms;
    logic [15:0] drift_ms;
  } cfg_t;

  // exp(-2^(k-16)) in q32
  function automatic logic [31:0] decay_q32(input logic [4:0] k);
    logic [31:0] t;
    case (k)
      5'd0: t = 32'd4294901760;
      5'd1: t = 32'd4294836226;
      5'd2: t = 32'd4294705160;
      5'd3: t = 32'd4294443040;
      5'd4: t = 32'd4293918848;
      5'd5: t = 32'd4292870656;
      5'd6: t = 32'd4290775039;
      5'd7: t = 32'd4286586875;
      5'd8: t = 32'd4278222805;
      5'd9: t = 32'd4261543595;
      5'd10: t = 32'd4228380000;
      5'd11: t = 32'd4162825044;
      5'd12: t = 32'd4034748382;
      5'd13: t = 32'd3790295335;
      5'd14: t = 32'd3344923893;
      5'd15: t = 32'd2605029347;
      5'd16: t = 32'd1580030169;
      5'd17: t = 32'd581260615;
      5'd18: t = 32'd78665070;
      5'd19: t = 32'd144080;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

  function automatic logic [POS_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic [POS_W-1:0] r;
    if (v > $signed({{(ACC_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}})) begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end else if (v < $signed({{(ACC_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}})) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

### src/media_clock_interpolator_unit.sv
// media clock interpolator
// input stream s_*: one transaction is a snapshot update (s_tuser = 0) or a
// position query (s_tuser = 1); every transaction yields exactly one result
// transaction on m_* carrying the shown position and play state at wall_tick.
// configuration over apb: tick_freq at 0x0, offset_ms at 0x4, drift_correct_ms
// at 0x8; write only while no transaction is in flight.
// one item at a time: s_tready is high only while the sequencer is idle.
// all multiplies and divides run through one shared bit-serial
// multiply/divide unit. a position evaluation uses one multiply and one
// divide when playing with no correction, and up to two divides plus up to
// 23 multiplies with a decaying correction. an item needs one or two
// evaluations plus sequencing states; the next item can be taken in the
// cycle after the result is loaded.
// the result sits in an output register; a stalled m_tready only holds the
// block once the next result is ready to be loaded.
// sync reset restores control, config and media state, not the datapath.
module media_clock_interpolator_unit #(
  parameter int DECAY_TIME_MS = 300
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // wall_tick, snap_position_ms, snap_position_tick, timeline_generation,
  // snap_playing, identity_changed, rate_q16, rate_finite, zero pad
  input  logic [247:0] s_tdata,
  // command
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // shown_position_ms, is_playing, zero pad
  output logic [55:0]  m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int DK_W = 32 + $clog2(DECAY_TIME_MS + 1);
  localparam int TW = mcl_pkg::TICK_W;
  localparam int PW = mcl_pkg::POS_W;
  localparam int AW = mcl_pkg::ACC_W;
  localparam int RW = mcl_pkg::RATE_W;

  mcl_pkg::cfg_t     cfg;
  mcl_pkg::mdu_req_t req;
  logic [63:0]       mdu_a;
  logic [63:0]       mdu_b;
  logic [63:0]       mdu_d;
  logic              mdu_done;
  logic [127:0]      prod;

  mcl_pkg::state_t state, state_next, ret_state;

  logic          cmd;
  logic [TW-1:0] now;
  logic [PW-1:0] spos;
  logic [TW-1:0] stick;
  logic [31:0]   gen;
  logic          splay;
  logic          ident;
  logic [31:0]   rate_in;
  logic          rfin;

  logic [PW-1:0] anchor_pos;
  logic [TW-1:0] anchor_tick;
  logic [RW-1:0] active_rate;
  logic          playing;
  logic [31:0]   corr;
  logic [TW-1:0] corr_start;
  logic [31:0]   last_gen;
  logic [RW-1:0] last_rate;
  logic          last_splay;
  logic          anchored;
  logic          seen;

  logic [TW-1:0] pos_t;
  logic [AW-1:0] acc;
  logic [32:0]   cval;
  logic [mcl_pkg::FAC_BITS-1:0] u;
  logic [32:0]   fac;
  logic [4:0]    k;
  logic [PW-1:0] pos_res;

  logic          out_valid;
  logic [PW-1:0] out_pos;
  logic          out_play;

  logic [RW-1:0] rate_eff;
  logic          tl_chg;
  logic          play_chg;
  logic          rate_chg;
  logic [31:0]   rd;
  logic [TW-1:0] ptick;
  logic          force_snap;
  logic          need_old;
  logic          call_pos;
  logic [TW-1:0] call_t;
  mcl_pkg::state_t call_ret;
  logic [TW-1:0] dt;
  logic [40:0]   rate_k;
  logic [DK_W-1:0] tf_k;
  logic [31:0]   mag;
  logic [32:0]   rnd;
  logic [49:0]   target;
  logic [50:0]   diff;
  logic [50:0]   absd;
  logic          tf_nz;
  logic          in_acc;

  mcl_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  mcl_mdu u_mdu (
    .clk, .rst, .req, .a(mdu_a), .b(mdu_b), .d(mdu_d), .done(mdu_done), .prod
  );

  assign s_tready = (state == mcl_pkg::S_IDLE);
  assign in_acc = s_tvalid & s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata = {7'd0, out_play, out_pos};
  assign tf_nz = (cfg.tick_freq != 32'd0);

  always_comb begin
    rate_eff = !rfin ? mcl_pkg::ONE_Q16 : (rate_in[31] ? '0 : rate_in[RW-1:0]);
    tl_chg = !seen || (gen != last_gen);
    play_chg = seen && (splay != last_splay);
    rd = {1'b0, rate_eff} - {1'b0, last_rate};
    if (rd[31]) begin
      rd = -rd;
    end
    rate_chg = seen && (rd > mcl_pkg::RATE_EPS_LSB);
    ptick = ((gen != 32'd0) && (stick <= now)) ? stick : now;
    force_snap = ident || play_chg || !splay;
    need_old = anchored && !force_snap;
    dt = (pos_t > anchor_tick) ? pos_t - anchor_tick : '0;
    rate_k = 41'(active_rate) * mcl_pkg::ADV_SCALE;
    tf_k = DK_W'(cfg.tick_freq) * DK_W'(DECAY_TIME_MS);
    mag = corr[31] ? -corr : corr;
    rnd = prod[64:32] + 33'(prod[31]);
    target = 50'($signed(spos)) + 50'($signed(cfg.offset_ms));
    diff = 51'($signed(target)) - 51'($signed(pos_res));
    absd = diff[50] ? -diff : diff;
  end

  always_comb begin
    state_next = state;
    req = '{start: 1'b0, op: mcl_pkg::OP_MUL};
    mdu_a = '0;
    mdu_b = '0;
    mdu_d = '0;
    call_pos = 1'b0;
    call_t = now;
    call_ret = mcl_pkg::S_DONE;
    case (state)
      mcl_pkg::S_IDLE: begin
        if (in_acc) begin
          state_next = mcl_pkg::S_DECODE;
        end
      end
      mcl_pkg::S_DECODE: begin
        if (cmd) begin
          state_next = mcl_pkg::S_FINAL;
        end else if (ident || tl_chg) begin
          if (need_old) begin
            call_pos = 1'b1;
            call_t = ptick;
            call_ret = mcl_pkg::S_ANCHOR;
            state_next = mcl_pkg::P_START;
          end else begin
            state_next = mcl_pkg::S_ANCHOR;
          end
        end else if (play_chg) begin
          if (splay != playing) begin
            call_pos = 1'b1;
            call_ret = mcl_pkg::S_PLAY;
            state_next = mcl_pkg::P_START;
          end else begin
            state_next = mcl_pkg::S_PLAY;
          end
        end else if (rate_chg) begin
          call_pos = 1'b1;
          call_ret = mcl_pkg::S_RATE;
          state_next = mcl_pkg::P_START;
        end else begin
          state_next = mcl_pkg::S_LAST;
        end
      end
      mcl_pkg::S_ANCHOR, mcl_pkg::S_PLAY, mcl_pkg::S_RATE: begin
        state_next = mcl_pkg::S_LAST;
      end
      mcl_pkg::S_LAST: begin
        state_next = mcl_pkg::S_FINAL;
      end
      mcl_pkg::S_FINAL: begin
        call_pos = 1'b1;
        call_ret = mcl_pkg::S_DONE;
        state_next = mcl_pkg::P_START;
      end
      mcl_pkg::S_DONE: begin
        if (!out_valid || m_tready) begin
          state_next = mcl_pkg::S_IDLE;
        end
      end
      mcl_pkg::P_START: begin
        if (playing && tf_nz) begin
          req = '{start: 1'b1, op: mcl_pkg::OP_MUL};
          mdu_a = 64'(dt);
          mdu_b = 64'(rate_k);
          state_next = mcl_pkg::P_ADV_MUL;
        end else begin
          state_next = mcl_pkg::P_OFF;
        end
      end
      mcl_pkg::P_ADV_MUL: begin
        if (mdu_done) begin
          req = '{start: 1'b1, op: mcl_pkg::OP_DIV};
          mdu_d = {16'd0, cfg.tick_freq, 16'd0};
          state_next = mcl_pkg::P_ADV_DIV;
        end
      end
      mcl_pkg::P_ADV_DIV: begin
        if (mdu_done) begin
          state_next = mcl_pkg::P_OFF;
        end
      end
      mcl_pkg::P_OFF: begin
        if ((corr != 32'd0) && tf_nz && (pos_t > corr_start)) begin
          req = '{start: 1'b1, op: mcl_pkg::OP_MUL};
          mdu_a = 64'(pos_t - corr_start);
          mdu_b = mcl_pkg::DECAY_NUM;
          state_next = mcl_pkg::P_DEC_MUL;
        end else begin
          state_next = mcl_pkg::P_SUM;
        end
      end
      mcl_pkg::P_DEC_MUL: begin
        if (mdu_done) begin
          req = '{start: 1'b1, op: mcl_pkg::OP_DIV};
          mdu_d = 64'(tf_k);
          state_next = mcl_pkg::P_DEC_DIV;
        end
      end
      mcl_pkg::P_DEC_DIV: begin
        if (mdu_done) begin
          state_next = (prod[63:mcl_pkg::FAC_BITS] != '0) ? mcl_pkg::P_SUM : mcl_pkg::P_FAC;
        end
      end
      mcl_pkg::P_FAC: begin
        if (k == 5'(mcl_pkg::FAC_BITS)) begin
          req = '{start: 1'b1, op: mcl_pkg::OP_MUL};
          mdu_a = 64'(mag);
          mdu_b = 64'(fac);
          state_next = mcl_pkg::P_MAG;
        end else if (u[k]) begin
          req = '{start: 1'b1, op: mcl_pkg::OP_MUL};
          mdu_a = 64'(fac);
          mdu_b = 64'(mcl_pkg::decay_q32(k));
          state_next = mcl_pkg::P_FAC_MUL;
        end
      end
      mcl_pkg::P_FAC_MUL: begin
        if (mdu_done) begin
          state_next = mcl_pkg::P_FAC;
        end
      end
      mcl_pkg::P_MAG: begin
        if (mdu_done) begin
          state_next = mcl_pkg::P_SUM;
        end
      end
      mcl_pkg::P_SUM: begin
        state_next = ret_state;
      end
      default: state_next = mcl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd <= s_tuser[0];
      now <= s_tdata[62:0];
      spos <= s_tdata[110:63];
      stick <= s_tdata[173:111];
      gen <= s_tdata[205:174];
      splay <= s_tdata[206];
      ident <= s_tdata[207];
      rate_in <= s_tdata[239:208];
      rfin <= s_tdata[240];
    end
    if (call_pos) begin
      pos_t <= call_t;
      ret_state <= call_ret;
    end
    case (state)
      mcl_pkg::P_START: acc <= AW'($signed(anchor_pos));
      mcl_pkg::P_ADV_DIV: begin
        if (mdu_done) begin
          acc <= acc + ((prod[63:0] > 64'h1_0000_0000_0000) ?
                        AW'(65'h1_0000_0000_0000) : AW'(prod[48:0]));
        end
      end
      mcl_pkg::P_OFF: begin
        acc <= acc + AW'($signed(cfg.offset_ms));
        cval <= 33'($signed(corr));
      end
      mcl_pkg::P_DEC_DIV: begin
        if (mdu_done) begin
          cval <= '0;
          u <= prod[mcl_pkg::FAC_BITS-1:0];
          fac <= 33'h1_0000_0000;
          k <= '0;
        end
      end
      mcl_pkg::P_FAC: begin
        if ((k != 5'(mcl_pkg::FAC_BITS)) && !u[k]) begin
          k <= k + 5'd1;
        end
      end
      mcl_pkg::P_FAC_MUL: begin
        if (mdu_done) begin
          fac <= prod[64:32];
          k <= k + 5'd1;
        end
      end
      mcl_pkg::P_MAG: begin
        if (mdu_done) begin
          cval <= corr[31] ? -rnd : rnd;
        end
      end
      mcl_pkg::P_SUM: pos_res <= mcl_pkg::sat48(acc + AW'($signed(cval)));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_pos <= '0;
      anchor_tick <= '0;
      active_rate <= mcl_pkg::ONE_Q16;
      playing <= 1'b0;
      corr <= '0;
      corr_start <= '0;
      last_gen <= '0;
      last_rate <= mcl_pkg::ONE_Q16;
      last_splay <= 1'b0;
      anchored <= 1'b0;
      seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != mcl_pkg::S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        mcl_pkg::S_ANCHOR: begin
          anchor_pos <= spos;
          active_rate <= rate_eff;
          anchored <= 1'b1;
          if ((splay != playing) && !splay) begin
            anchor_tick <= now;
            corr_start <= now;
            corr <= '0;
          end else begin
            anchor_tick <= ptick;
            corr_start <= ptick;
            corr <= (need_old && (absd <= 51'(cfg.drift_ms))) ? 32'(-diff) : '0;
          end
          if (splay != playing) begin
            playing <= splay;
          end
        end
        mcl_pkg::S_PLAY: begin
          if (splay != playing) begin
            anchor_pos <= mcl_pkg::sat48(AW'($signed(pos_res)) - AW'($signed(cfg.offset_ms)));
            anchor_tick <= now;
            corr <= '0;
            corr_start <= now;
            playing <= splay;
          end
          active_rate <= rate_eff;
        end
        mcl_pkg::S_RATE: begin
          anchor_pos <= mcl_pkg::sat48(AW'($signed(pos_res)) - AW'($signed(cfg.offset_ms)));
          anchor_tick <= now;
          active_rate <= rate_eff;
          corr <= '0;
          corr_start <= now;
          anchored <= 1'b1;
        end
        mcl_pkg::S_LAST: begin
          last_gen <= gen;
          last_rate <= rate_eff;
          last_splay <= splay;
          seen <= 1'b1;
        end
        mcl_pkg::S_DONE: begin
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            out_pos <= pos_res;
            out_play <= playing;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### src/mcl_cfg.sv
module mcl_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mcl_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output mcl_pkg::cfg_t             cfg
);

  logic [1:0] idx;
  logic       wr;

  assign idx = paddr[3:2];
  assign wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_freq <= mcl_pkg::TICK_FREQ_RST;
      cfg.offset_ms <= 32'd0;
      cfg.drift_ms <= 16'd0;
    end else if (wr) begin
      case (idx)
        mcl_pkg::REG_TICK_FREQ: cfg.tick_freq <= pwdata;
        mcl_pkg::REG_OFFSET: cfg.offset_ms <= pwdata;
        mcl_pkg::REG_DRIFT: cfg.drift_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mcl_pkg::REG_TICK_FREQ: prdata = cfg.tick_freq;
      mcl_pkg::REG_OFFSET: prdata = cfg.offset_ms;
      mcl_pkg::REG_DRIFT: prdata = {16'd0, cfg.drift_ms};
      default: prdata = 32'd0;
    endcase
  end

endmodule

### src/mcl_mdu.sv
module mcl_mdu (
  input  logic               clk,
  input  logic               rst,
  input  mcl_pkg::mdu_req_t  req,
  input  logic [63:0]        a,
  input  logic [63:0]        b,
  input  logic [63:0]        d,
  output logic               done,
  output logic [127:0]       prod
);

  logic [127:0] p;
  logic [63:0]  mcand;
  logic [63:0]  dsr;
  logic [5:0]   cnt;
  logic         run;
  mcl_pkg::mdu_op_t op;
  logic [64:0]  sum;
  logic [63:0]  rem2;
  logic         take;

  assign prod = p;

  // shift-add multiply, restoring divide, one bit per cycle
  always_comb begin
    sum = {1'b0, p[127:64]} + (p[0] ? {1'b0, mcand} : 65'd0);
    rem2 = p[126:63];
    take = p[127] | (rem2 >= dsr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= (req.start && (req.op == mcl_pkg::OP_DIV) && (p[127:64] >= d)) ||
              (!req.start && run && (cnt == 6'd63));
      if (req.start) begin
        op <= req.op;
        cnt <= 6'd0;
        case (req.op)
          mcl_pkg::OP_MUL: begin
            p <= {64'd0, b};
            mcand <= a;
            run <= 1'b1;
          end
          mcl_pkg::OP_DIV: begin
            dsr <= d;
            if (p[127:64] >= d) begin
              p[63:0] <= '1;
            end else begin
              run <= 1'b1;
            end
          end
          default: ;
        endcase
      end else if (run) begin
        if (op == mcl_pkg::OP_MUL) begin
          p <= {sum, p[63:1]};
        end else if (take) begin
          p <= {rem2 - dsr, p[62:0], 1'b1};
        end else begin
          p <= {rem2, p[62:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run <= 1'b0;
        end
      end
    end
  end

endmodule

### src/mcl_chk.sv
module mcl_chk (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [55:0]  m_tdata
);

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken while busy");

  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
    else $error("result appeared without computation time");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind media_clock_interpolator_unit mcl_chk u_mcl_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam bit CMD_SNAP = 1'b0;
  localparam bit CMD_QUERY = 1'b1;
  localparam int DECAY_MS = 300;
  localparam longint unsigned CYCLE_LIMIT = 64'd60000000;
  localparam longint POS_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint POS_LO = -64'sh0000_8000_0000_0000;
  localparam bit [31:0] EXP_STEP_Q32 [20] = '{
    32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040, 32'd4293918848,
    32'd4292870656, 32'd4290775039, 32'd4286586875, 32'd4278222805, 32'd4261543595,
    32'd4228380000, 32'd4162825044, 32'd4034748382, 32'd3790295335, 32'd3344923893,
    32'd2605029347, 32'd1580030169, 32'd581260615, 32'd78665070, 32'd144080
  };

  typedef struct {
    bit cmd;
    bit [62:0] wall;
    bit signed [47:0] spos;
    bit [62:0] stick;
    bit [31:0] gen;
    bit splay;
    bit ident;
    bit signed [31:0] rate;
    bit finite;
  } media_item_t;

  typedef struct {
    bit [47:0] pos;
    bit play;
  } shown_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [247:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  media_clock_interpolator_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  bit [31:0] cfg_freq;
  longint cfg_offset;
  longint cfg_drift;
  longint anc_pos;
  bit [63:0] anc_tick;
  longint act_rate;
  bit playing;
  longint corr_amt;
  bit [63:0] corr_start;
  bit [31:0] last_gen;
  longint last_rate;
  bit last_splay;
  bit anchored;
  bit seen;

  media_item_t offer_q[$];
  shown_t shown_expect_q[$];
  int errors = 0;
  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int recv_hold = 0;
  bit calm = 1'b0;
  longint unsigned cycles = 0;

  function automatic bit [63:0] scaled_div(bit [63:0] a, bit [63:0] b, bit [63:0] d);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:64] >= d) return '1;
    return 64'(p / {64'd0, d});
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  function automatic longint decayed(longint c, bit [63:0] start, bit [63:0] now);
    bit [63:0] u;
    bit [63:0] f;
    bit [63:0] mag;
    bit [63:0] r;
    if (c == 0 || cfg_freq == 0 || now <= start) return c;
    u = scaled_div(now - start, 64'd65536000, {32'd0, cfg_freq} * 64'(DECAY_MS));
    if (u >= 64'd1 << 20) return 0;
    f = 64'd1 << 32;
    for (int k = 0; k < 20; k++)
      if (u[k]) f = (f * {32'd0, EXP_STEP_Q32[k]}) >> 32;
    mag = (c < 0) ? 64'(-c) : 64'(c);
    r = (mag * f + (64'd1 << 31)) >> 32;
    return (c < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint position_now(bit [63:0] now);
    longint t;
    bit [63:0] dt;
    bit [63:0] d;
    t = anc_pos;
    if (playing && cfg_freq > 0) begin
      dt = (now > anc_tick) ? now - anc_tick : 64'd0;
      d = scaled_div(dt, 64'(act_rate * 1000), {32'd0, cfg_freq} << 16);
      if (d > 64'd1 << 48) d = 64'd1 << 48;
      t += longint'(d);
    end
    t += cfg_offset;
    t += decayed(corr_amt, corr_start, now);
    return clamp_pos(t);
  endfunction

  task automatic reanchor(longint pos, bit [63:0] tick, longint rate, bit snap);
    bit had;
    longint old;
    longint target;
    longint diff;
    had = anchored;
    old = had ? position_now(tick) : 0;
    anc_pos = clamp_pos(pos);
    anc_tick = tick;
    act_rate = rate;
    corr_amt = 0;
    corr_start = tick;
    anchored = 1'b1;
    if (had && !snap) begin
      target = anc_pos + cfg_offset;
      diff = target - old;
      if (diff < 0) diff = -diff;
      if (diff <= cfg_drift) corr_amt = old - target;
    end
  endtask

  task automatic change_play(bit play, bit [63:0] now, bit keep);
    if (play == playing) return;
    if (play) begin
      if (!keep) begin
        anc_pos = clamp_pos(position_now(now) - cfg_offset);
        anc_tick = now;
        corr_amt = 0;
        corr_start = now;
      end
    end else begin
      if (keep) anc_pos = clamp_pos(anc_pos + decayed(corr_amt, corr_start, now));
      else anc_pos = clamp_pos(position_now(now) - cfg_offset);
      anc_tick = now;
      corr_amt = 0;
      corr_start = now;
    end
    playing = play;
  endtask

  task automatic predict_shown(media_item_t it);
    bit [63:0] now;
    longint rate;
    longint rd;
    bit tl_chg;
    bit play_chg;
    bit rate_chg;
    bit [63:0] ptick;
    shown_t s;
    now = {1'b0, it.wall};
    if (it.cmd == CMD_SNAP) begin
      rate = longint'(it.rate);
      if (!it.finite) rate = 65536;
      else if (rate < 0) rate = 0;
      tl_chg = !seen || it.gen != last_gen;
      play_chg = seen && it.splay != last_splay;
      rd = rate - last_rate;
      if (rd < 0) rd = -rd;
      rate_chg = seen && rd > 65;
      ptick = (it.gen != 0 && {1'b0, it.stick} <= now) ? {1'b0, it.stick} : now;
      if (it.ident || tl_chg) begin
        reanchor(longint'(it.spos), ptick, rate, it.ident || play_chg || !it.splay);
        change_play(it.splay, now, 1'b1);
      end else if (play_chg) begin
        change_play(it.splay, now, 1'b0);
        act_rate = rate;
      end else if (rate_chg) begin
        reanchor(position_now(now) - cfg_offset, now, rate, 1'b1);
      end
      last_gen = it.gen;
      last_rate = rate;
      last_splay = it.splay;
      seen = 1'b1;
    end
    s.pos = 48'(position_now(now));
    s.play = playing;
    shown_expect_q.push_back(s);
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // sampling and checking
  always @(posedge clk) begin
    shown_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_shown(offer_q.pop_front());
        in_fire = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        out_fire = 1'b1;
        if (shown_expect_q.size() == 0) begin
          report("unexpected transaction", m_tdata, 0);
        end else begin
          e = shown_expect_q.pop_front();
          if (m_tdata[47:0] !== e.pos) report("shown_position_ms", m_tdata[47:0], e.pos);
          if (m_tdata[48] !== e.play) report("is_playing", m_tdata[48], e.play);
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    bit nv;
    media_item_t it;
    nv = s_tvalid;
    if (s_tvalid && in_fire) begin
      in_fire = 1'b0;
      nv = 1'b0;
      send_gap = calm ? 0 : $urandom_range(0, 7);
    end
    if (!nv && !rst) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (offer_q.size() > 0) begin
        it = offer_q[0];
        s_tdata <= {7'd0, it.finite, it.rate, it.ident, it.splay, it.gen, it.stick,
                    it.spos, it.wall};
        s_tuser <= it.cmd;
        nv = 1'b1;
      end
    end
    s_tvalid <= nv;
  end

  // result receiver
  always @(negedge clk) begin
    bit nr;
    if (out_fire) begin
      out_fire = 1'b0;
      recv_gap = calm ? 0 : $urandom_range(0, 7);
    end
    if (rst) nr = 1'b0;
    else if (recv_hold > 0) begin
      recv_hold--;
      nr = 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      nr = 1'b0;
    end else nr = 1'b1;
    m_tready <= nr;
  end

  task automatic reg_write(logic [1:0] idx, bit [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      mcl_pkg::REG_TICK_FREQ: cfg_freq = val;
      mcl_pkg::REG_OFFSET: cfg_offset = longint'(signed'(val));
      mcl_pkg::REG_DRIFT: cfg_drift = longint'(val[15:0]);
      default: ;
    endcase
  endtask

  task automatic drain();
    while (offer_q.size() > 0 || shown_expect_q.size() > 0 || s_tvalid) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic media_item_t snap(bit [62:0] wall, longint pos, bit [62:0] stick,
                                       bit [31:0] gen, bit play, bit ident,
                                       bit [31:0] rate, bit fin);
    media_item_t it;
    it.cmd = CMD_SNAP;
    it.wall = wall;
    it.spos = 48'(pos);
    it.stick = stick;
    it.gen = gen;
    it.splay = play;
    it.ident = ident;
    it.rate = rate;
    it.finite = fin;
    return it;
  endfunction

  function automatic media_item_t query(bit [62:0] wall);
    media_item_t it;
    it = snap(wall, 0, 0, 0, 0, 0, 0, 0);
    it.cmd = CMD_QUERY;
    return it;
  endfunction

  function automatic media_item_t noise();
    media_item_t it;
    it.cmd = 1'($urandom_range(0, 1));
    it.wall = 63'({$urandom, $urandom});
    it.spos = 48'({$urandom, $urandom});
    it.stick = 63'({$urandom, $urandom});
    it.gen = $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 2)) : $urandom;
    it.splay = 1'($urandom_range(0, 1));
    it.ident = 1'($urandom_range(0, 1));
    it.rate = $urandom;
    it.finite = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // plausible playback traffic with jittered reports, plus random noise items
  task automatic random_run(int n, int step_max);
    bit [62:0] now;
    longint media;
    bit [31:0] gen;
    bit play;
    bit [31:0] rate;
    int sel;
    now = 63'($urandom_range(0, 1000000));
    media = longint'($urandom_range(0, 100000));
    gen = 1;
    play = 1'b1;
    rate = 32'd65536;
    for (int i = 0; i < n; i++) begin
      now += 63'($urandom_range(0, step_max));
      media += longint'($urandom_range(0, 50));
      sel = $urandom_range(0, 99);
      if (sel < 50) offer_q.push_back(query(now + 63'($urandom_range(0, 100))));
      else if (sel < 90) begin
        if ($urandom_range(0, 5) == 0) gen++;
        if ($urandom_range(0, 9) == 0) play = !play;
        if ($urandom_range(0, 7) == 0) rate = 32'($urandom_range(0, 200000));
        offer_q.push_back(snap(now, media + longint'($urandom_range(0, 300)) - 150,
                               now - 63'($urandom_range(0, 2000)) +
                               ($urandom_range(0, 9) == 0 ? 63'd5000 : 63'd0),
                               gen, play, $urandom_range(0, 19) == 0, rate,
                               $urandom_range(0, 15) != 0));
      end else offer_q.push_back(noise());
    end
  endtask

  initial begin
    cfg_freq = mcl_pkg::TICK_FREQ_RST;
    cfg_offset = 0;
    cfg_drift = 0;
    anc_pos = 0;
    anc_tick = 0;
    act_rate = 65536;
    playing = 1'b0;
    corr_amt = 0;
    corr_start = 0;
    last_gen = 0;
    last_rate = 65536;
    last_splay = 1'b0;
    anchored = 1'b0;
    seen = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    reg_write(mcl_pkg::REG_DRIFT, 32'd100);
    offer_q.push_back(query(0));
    offer_q.push_back(snap(1000, 1000, 500, 1, 1, 0, 32'd65536, 1));
    offer_q.push_back(query(2000000));
    offer_q.push_back(snap(2100000, 3130, 2050000, 2, 1, 0, 32'd65536, 1));
    offer_q.push_back(query(2200000));
    offer_q.push_back(query(12000000));
    offer_q.push_back(snap(12000000, 0, 0, 2, 1, 0, 32'd131072, 1));
    offer_q.push_back(snap(13000000, 0, 0, 2, 1, 0, 32'h7FFF_FFFF, 0));
    offer_q.push_back(snap(14000000, 0, 0, 2, 1, 0, 32'h8000_0000, 1));
    offer_q.push_back(snap(15000000, 20000, 16000000, 3, 1, 0, 32'd65536, 1));
    offer_q.push_back(snap(16000000, 21000, 15500000, 0, 1, 0, 32'd65536, 1));
    offer_q.push_back(snap(17000000, 0, 0, 0, 0, 0, 32'd65536, 1));
    offer_q.push_back(query(18000000));
    offer_q.push_back(snap(19000000, 0, 0, 0, 1, 0, 32'd65536, 1));
    offer_q.push_back(snap(19500000, 500, 19400000, 0, 1, 1, 32'd65536, 1));
    offer_q.push_back(query(100));
    offer_q.push_back(snap(20000000, POS_HI, 20000000, 4, 1, 1, 32'h7FFF_FFFF, 1));
    offer_q.push_back(query('1));
    offer_q.push_back(snap('1, POS_LO, '1, 32'hFFFF_FFFF, 0, 1, 32'd65536, 1));
    offer_q.push_back(query('1));
    drain();

    reg_write(mcl_pkg::REG_TICK_FREQ, 32'd1000);
    reg_write(mcl_pkg::REG_OFFSET, -32'sd7);
    reg_write(mcl_pkg::REG_DRIFT, 32'd50);
    recv_hold = 3000;
    random_run(300, 200);
    drain();

    reg_write(mcl_pkg::REG_TICK_FREQ, 32'd0);
    reg_write(mcl_pkg::REG_OFFSET, 32'h7FFF_FFFF);
    reg_write(mcl_pkg::REG_DRIFT, 32'd65535);
    random_run(100, 1000);
    drain();

    reg_write(mcl_pkg::REG_TICK_FREQ, 32'hFFFF_FFFF);
    reg_write(mcl_pkg::REG_OFFSET, 32'h8000_0000);
    reg_write(mcl_pkg::REG_DRIFT, 32'd0);
    calm = 1'b1;
    random_run(100, 100000000);
    drain();

    calm = 1'b0;
    reg_write(mcl_pkg::REG_TICK_FREQ, 32'd48000);
    reg_write(mcl_pkg::REG_OFFSET, 32'd0);
    reg_write(mcl_pkg::REG_DRIFT, 32'd200);
    random_run(500, 20000);
    drain();

    repeat (100) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
src/mcl_pkg.sv
src/mcl_cfg.sv
src/mcl_mdu.sv
src/media_clock_interpolator_unit.sv
src/mcl_chk.sv
tb/sv/testbench.sv
